>>> design/mwtl_pkg.sv
// ----------------------------------------------------------------------------
// mwtl_pkg
// Shared types, register indexes and helpers for the minute window logger.
// ----------------------------------------------------------------------------
package mwtl_pkg;

    // register indexes on the configuration channel
    typedef enum logic [2:0] {
        CFG_LOG_ENABLE   = 3'd0,
        CFG_ALARM_ENABLE = 3'd1,
        CFG_START_HOUR   = 3'd2,
        CFG_START_MINUTE = 3'd3,
        CFG_END_HOUR     = 3'd4,
        CFG_END_MINUTE   = 3'd5,
        CFG_UPPER_LIMIT  = 3'd6,
        CFG_LOWER_LIMIT  = 3'd7
    } cfg_index_t;

    localparam int CFG_DATA_W   = 8;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 40;
    localparam int M_TUSER_W    = 2;
    localparam int TS_W         = 12;

    // ticks after which a record is due, minutes per hour, alarm margin
    localparam logic [7:0]      TICKS_PER_MIN = 8'd59;
    localparam logic [TS_W-1:0] MIN_PER_HOUR  = 12'd60;
    localparam logic [8:0]      NEAR_MARGIN   = 9'd5;
    localparam logic [7:0]      UPPER_RESET   = 8'd255;

    typedef struct packed {
        logic       log_enable;
        logic       alarm_enable;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
        logic [7:0] upper_limit;
        logic [7:0] lower_limit;
    } cfg_t;

    typedef struct packed {
        logic [3:0] last_seconds_digit;
        logic [7:0] tick_count;
        logic       warning_state;
        logic       alarm_state;
        logic       buzzer_state;
    } state_t;

    typedef struct packed {
        logic [7:0] temperature;
        logic [7:0] year_bcd;
        logic [4:0] month_bcd;
        logic [5:0] date_bcd;
        logic [6:0] minute_bcd;
        logic [5:0] hour_bcd;
        logic [3:0] seconds_units;
    } in_item_t;

    typedef struct packed {
        logic       tick_seen;
        logic       record_valid;
        logic       buzzer_on;
        logic       alarm_led;
        logic       warning_led;
        logic [6:0] record_year;
        logic [3:0] record_month;
        logic [4:0] record_date;
        logic [5:0] record_minute;
        logic [4:0] record_hour;
        logic [7:0] record_temp;
    } result_t;

    // tens*10+units at full precision, tens up to four bits
    function automatic logic [7:0] bcd_to_bin(input logic [3:0] tens, input logic [3:0] units);
        logic [7:0] t8;
        t8 = {4'd0, tens};
        return (t8 << 3) + (t8 << 1) + {4'd0, units};
    endfunction

    // hour*60+minute
    function automatic logic [TS_W-1:0] to_minutes(input logic [7:0] hr, input logic [7:0] mn);
        logic [TS_W-1:0] h;
        h = {{(TS_W-8){1'b0}}, hr};
        return (h * MIN_PER_HOUR) + {{(TS_W-8){1'b0}}, mn};
    endfunction

endpackage

>>> design/minute_window_temp_logger.sv
// ----------------------------------------------------------------------------
// minute_window_temp_logger
// Once-a-minute temperature logger with window test and limit indicators.
// ----------------------------------------------------------------------------
// Each item on the s_ channel is one poll of the clock chip and the sensor.
// A change of the seconds digit is a tick; the sixtieth tick with logging on
// produces a record when the time of day lies in the configured window.
// Every accepted item gives exactly one item on the m_ channel carrying the
// record (zeros when none), the indicator states and the tick flag.
// Registers are written through the cfg_ channel, always ready; writes are
// meant to happen only while the block holds no item.
// An accepted item sits in the input register, is evaluated combinationally
// and is loaded into the output register, from which it is offered on m_.
// Throughput: one item per cycle while m_ is free; single register stage loop.
// A stalled receiver holds the output register; the input register keeps
// one further item, after which s_tready falls until m_tready returns.
// Reset (aresetn low, synchronous) empties both registers, clears the tick
// state and indicators and sets the registers to their reset values.
// ----------------------------------------------------------------------------
module minute_window_temp_logger (
    input  logic                              aclk,
    input  logic                              aresetn,
    // seconds_units, hour_bcd, minute_bcd, date_bcd, month_bcd, year_bcd,
    // temperature, then zero fill
    input  logic [mwtl_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // record_temp, record_hour, record_minute, record_date, record_month,
    // record_year, warning_led, alarm_led, buzzer_on, then zero fill
    output logic [mwtl_pkg::M_TDATA_W-1:0]    m_tdata,
    // record_valid, tick_seen
    output logic [mwtl_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [mwtl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mwtl_pkg::cfg_t     cfg_reg;
    mwtl_pkg::state_t   state_reg;
    mwtl_pkg::state_t   state_next;
    mwtl_pkg::in_item_t in_reg;
    logic               in_valid_reg;
    mwtl_pkg::result_t  res_reg;
    mwtl_pkg::result_t  res_next;
    logic               out_valid_reg;
    logic               out_free;
    logic               advance;
    logic               s_accept;

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{
                log_enable:   1'b0,
                alarm_enable: 1'b0,
                start_hour:   5'd0,
                start_minute: 6'd0,
                end_hour:     5'd0,
                end_minute:   6'd0,
                upper_limit:  mwtl_pkg::UPPER_RESET,
                lower_limit:  8'd0
            };
        end else if (cfg_valid) begin
            unique case (mwtl_pkg::cfg_index_t'(cfg_index))
                mwtl_pkg::CFG_LOG_ENABLE:   cfg_reg.log_enable   <= cfg_data[0];
                mwtl_pkg::CFG_ALARM_ENABLE: cfg_reg.alarm_enable <= cfg_data[0];
                mwtl_pkg::CFG_START_HOUR:   cfg_reg.start_hour   <= cfg_data[4:0];
                mwtl_pkg::CFG_START_MINUTE: cfg_reg.start_minute <= cfg_data[5:0];
                mwtl_pkg::CFG_END_HOUR:     cfg_reg.end_hour     <= cfg_data[4:0];
                mwtl_pkg::CFG_END_MINUTE:   cfg_reg.end_minute   <= cfg_data[5:0];
                mwtl_pkg::CFG_UPPER_LIMIT:  cfg_reg.upper_limit  <= cfg_data;
                mwtl_pkg::CFG_LOWER_LIMIT:  cfg_reg.lower_limit  <= cfg_data;
                default: ;
            endcase
        end
    end

    // evaluation between input and output register
    mwtl_eval u_eval (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // control: valid flags and tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= mwtl_pkg::in_item_t'(s_tdata[43:0]);
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg[37:0]};
    assign m_tuser  = {res_reg.tick_seen, res_reg.record_valid};

endmodule

>>> design/mwtl_eval.sv
// ----------------------------------------------------------------------------
// mwtl_eval
// Per-item evaluation: tick detection, minute count, window test, indicators.
// ----------------------------------------------------------------------------
module mwtl_eval (
    input  mwtl_pkg::cfg_t     cfg,
    input  mwtl_pkg::state_t   state,
    input  mwtl_pkg::in_item_t item,
    output mwtl_pkg::state_t   state_next,
    output mwtl_pkg::result_t  result
);

    logic                      tick;
    logic [7:0]                count_inc;
    logic                      minute_due;
    logic [7:0]                hr_bin;
    logic [7:0]                mn_bin;
    logic [7:0]                dt_bin;
    logic [7:0]                mo_bin;
    logic [7:0]                yr_bin;
    logic [mwtl_pkg::TS_W-1:0] now_ts;
    logic [mwtl_pkg::TS_W-1:0] start_ts;
    logic [mwtl_pkg::TS_W-1:0] end_ts;
    logic                      in_window;
    logic                      logged;
    logic [8:0]                temp9;
    logic [8:0]                upper9;
    logic [8:0]                lower9;
    logic                      near_limit;
    logic                      out_limit;

    // tick and minute count
    assign tick       = (item.seconds_units != state.last_seconds_digit);
    assign count_inc  = state.tick_count + 8'd1;
    assign minute_due = cfg.log_enable && (count_inc > mwtl_pkg::TICKS_PER_MIN);

    // bcd to binary, full precision
    assign hr_bin = mwtl_pkg::bcd_to_bin({2'd0, item.hour_bcd[5:4]}, item.hour_bcd[3:0]);
    assign mn_bin = mwtl_pkg::bcd_to_bin({1'd0, item.minute_bcd[6:4]}, item.minute_bcd[3:0]);
    assign dt_bin = mwtl_pkg::bcd_to_bin({2'd0, item.date_bcd[5:4]}, item.date_bcd[3:0]);
    assign mo_bin = mwtl_pkg::bcd_to_bin({3'd0, item.month_bcd[4]}, item.month_bcd[3:0]);
    assign yr_bin = mwtl_pkg::bcd_to_bin(item.year_bcd[7:4], item.year_bcd[3:0]);

    // window test, no midnight wrap
    assign now_ts    = mwtl_pkg::to_minutes(hr_bin, mn_bin);
    assign start_ts  = mwtl_pkg::to_minutes({3'd0, cfg.start_hour}, {2'd0, cfg.start_minute});
    assign end_ts    = mwtl_pkg::to_minutes({3'd0, cfg.end_hour}, {2'd0, cfg.end_minute});
    assign in_window = (now_ts >= start_ts) && (now_ts < end_ts);
    assign logged    = tick && minute_due && in_window;

    // limit tests, margin folded onto one side to stay unsigned
    assign temp9      = {1'b0, item.temperature};
    assign upper9     = {1'b0, cfg.upper_limit};
    assign lower9     = {1'b0, cfg.lower_limit};
    assign near_limit = (temp9 + mwtl_pkg::NEAR_MARGIN > upper9)
                     || (temp9 < lower9 + mwtl_pkg::NEAR_MARGIN);
    assign out_limit  = (temp9 > upper9) || (temp9 < lower9);

    // next state
    always_comb begin
        state_next = state;
        if (tick) begin
            state_next.last_seconds_digit = item.seconds_units;
            state_next.tick_count         = minute_due ? 8'd0 : count_inc;
            if (cfg.alarm_enable) begin
                state_next.warning_state = near_limit;
                state_next.alarm_state   = out_limit;
                state_next.buzzer_state  = out_limit;
            end else begin
                state_next.buzzer_state  = 1'b0;
            end
        end
    end

    // result item
    always_comb begin
        result               = '0;
        result.tick_seen     = tick;
        result.record_valid  = logged;
        result.warning_led   = state_next.warning_state;
        result.alarm_led     = state_next.alarm_state;
        result.buzzer_on     = state_next.buzzer_state;
        if (logged) begin
            result.record_temp   = item.temperature;
            result.record_hour   = hr_bin[4:0];
            result.record_minute = mn_bin[5:0];
            result.record_date   = dt_bin[4:0];
            result.record_month  = mo_bin[3:0];
            result.record_year   = yr_bin[6:0];
        end
    end

endmodule
